[hw/rtl/rrqe_pkg.sv]
package rrqe_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ID_W       = 31;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    typedef enum logic [1:0] {
        CMD_NEXT     = 2'd0,
        CMD_EXPEDITE = 2'd1,
        CMD_RESTART  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SERVED    = 2'd0,
        ST_EXPEDITED = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_RESTARTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_ROTATE = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_LOAD   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [ID_W-1:0]       key;
        logic [ID_W-1:0]       head_ident;
    } cell_ctrl_t;

endpackage

[hw/rtl/rrqe_cell.sv]
module rrqe_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rrqe_pkg::cell_ctrl_t      ctrl,
    input  logic                      shift_en,
    input  logic [rrqe_pkg::ID_W-1:0] left_ident,
    input  logic [rrqe_pkg::ID_W-1:0] right_ident,
    input  logic                      right_used,
    input  logic [rrqe_pkg::ID_W-1:0] restart_ident,
    input  logic                      restart_used,
    output logic [rrqe_pkg::ID_W-1:0] ident,
    output logic                      used,
    output logic                      match
);
    import rrqe_pkg::*;

    logic [ID_W-1:0] ident_reg;
    logic [ID_W-1:0] ident_next;
    logic            used_reg;
    logic            used_next;

    always_comb begin
        ident_next = ident_reg;
        used_next  = used_reg;
        unique case (ctrl.op)
            OP_HOLD: begin
            end
            OP_ROTATE: begin
                if (right_used) begin
                    ident_next = right_ident;
                end else if (used_reg) begin
                    ident_next = ctrl.head_ident;
                end
            end
            OP_SHIFT: begin
                if (shift_en) begin
                    ident_next = left_ident;
                    used_next  = 1'b1;
                end
            end
            OP_LOAD: begin
                ident_next = restart_ident;
                used_next  = restart_used;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ident_reg <= ident_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    assign ident = ident_reg;
    assign used  = used_reg;
    assign match = used_reg && (ident_reg == ctrl.key);

endmodule

[hw/rtl/round_robin_queue_with_expedite_top.sv]
// Ordered list of up to 64 distinct identifiers held in a row of cells, front
// at cell 0. A next command serves the front identifier and rotates it to the
// back, an expedite command moves or inserts an identifier at the front (or is
// rejected when the list is full and lacks it), and a restart loads
// 1..initial_count, at most 64. Every command completes in the cycle its beat
// is accepted: all cells compare the identifier in parallel and take their new
// value from a neighbor. The result waits in an output register, and one beat
// is accepted per cycle whenever that register is empty or is being drained.
module round_robin_queue_with_expedite_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [rrqe_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [rrqe_pkg::ID_W-1:0]  s_person_id,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [rrqe_pkg::ID_W-1:0]  m_served_id
);
    import rrqe_pkg::*;

    logic [CNT_W-1:0]  init_count_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [ID_W-1:0]   served_reg;
    logic [ID_W-1:0]   served_next;

    cell_ctrl_t        ctrl;
    logic              s_fire;
    logic              found;
    logic              full;

    logic [ID_W-1:0]       cell_ident [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_used;
    logic [LIST_DEPTH-1:0] cell_match;
    logic [LIST_DEPTH-1:0] shift_en;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign found   = |cell_match;
    assign full    = cell_used[LIST_DEPTH-1];

    always_comb begin
        ctrl.op         = OP_HOLD;
        ctrl.key        = s_person_id;
        ctrl.head_ident = cell_ident[0];
        status_next     = status_reg;
        served_next     = served_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (s_fire) begin
            m_valid_next = 1'b1;
            served_next  = '0;
            unique case (s_cmd)
                CMD_NEXT: begin
                    ctrl.op     = OP_ROTATE;
                    status_next = ST_SERVED;
                    served_next = cell_used[0] ? cell_ident[0] : '0;
                end
                CMD_EXPEDITE: begin
                    if (found || !full) begin
                        ctrl.op     = OP_SHIFT;
                        status_next = ST_EXPEDITED;
                    end else begin
                        status_next = ST_REJECTED;
                    end
                end
                default: begin
                    ctrl.op     = OP_LOAD;
                    status_next = ST_RESTARTED;
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
            logic [ID_W-1:0] left_ident;
            logic [ID_W-1:0] right_ident;
            logic            right_used;
            logic            restart_used;

            assign restart_used    = CMP_W'(i) < CMP_W'(init_count_reg);

            if (i == 0) begin : g_first
                assign left_ident  = s_person_id;
                assign shift_en[i] = 1'b1;
            end else begin : g_inner
                logic hit_at_or_after;

                assign hit_at_or_after = |cell_match[LIST_DEPTH-1:i];
                assign left_ident      = cell_ident[i-1];
                assign shift_en[i]     = found ? hit_at_or_after : cell_used[i-1];
            end

            if (i == LIST_DEPTH - 1) begin : g_last
                assign right_ident = '0;
                assign right_used  = 1'b0;
            end else begin : g_body
                assign right_ident = cell_ident[i+1];
                assign right_used  = cell_used[i+1];
            end

            rrqe_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl          (ctrl),
                .shift_en      (shift_en[i]),
                .left_ident    (left_ident),
                .right_ident   (right_ident),
                .right_used    (right_used),
                .restart_ident (restart_used ? ID_W'(i + 1) : '0),
                .restart_used  (restart_used),
                .ident         (cell_ident[i]),
                .used          (cell_used[i]),
                .match         (cell_match[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_count_reg <= CNT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                init_count_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        served_reg <= served_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_served_id = served_reg;

endmodule

[hw/rtl/rrqe_checker.sv]
module rrqe_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [1:0]                 s_cmd,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic [rrqe_pkg::ID_W-1:0]  m_served_id
);
    import rrqe_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_served_id))
        else $error("Result beat changed while stalled.");

    a_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_SERVED) |-> m_served_id == '0)
        else $error("Nonzero served identifier on a non-serve result.");

    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_NEXT) |=> m_valid && (m_status == ST_SERVED))
        else $error("Next command did not give a served result.");

    a_expedite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == CMD_EXPEDITE) |=>
            m_valid && ((m_status == ST_EXPEDITED) || (m_status == ST_REJECTED)))
        else $error("Expedite command gave a wrong status.");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd[1] == 1'b1) |=> m_valid && (m_status == ST_RESTARTED))
        else $error("Restart command gave a wrong status.");

endmodule

bind round_robin_queue_with_expedite_top rrqe_checker u_rrqe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_cmd       (s_cmd),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_served_id (m_served_id)
);
